[design/gate_controller_with_echo_ranging_assert.svh]
// assertion macros for the gate controller with echo ranging
// used by the top level only, expects a clock named clk and a reset named rst_n
`ifndef GATE_CONTROLLER_WITH_ECHO_RANGING_ASSERT_SVH
`define GATE_CONTROLLER_WITH_ECHO_RANGING_ASSERT_SVH

// same-cycle implication
`define GCER_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define GCER_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/gcer_pkg.sv]
// shared types, codes and helpers for the gate controller with echo ranging
// no dependencies
`timescale 1ns / 1ps

package gcer_pkg;

  localparam int TIME_W  = 32;
  localparam int DIST_W  = 16;
  localparam int SCALE_W = 20;
  localparam int FRAC_W  = 20;
  localparam int PROD_W  = TIME_W + SCALE_W;

  // configuration register indexes
  localparam logic [1:0] CFG_CLEAR_LOW  = 2'd0;
  localparam logic [1:0] CFG_CLEAR_HIGH = 2'd1;
  localparam logic [1:0] CFG_SCALE      = 2'd2;

  localparam logic [DIST_W-1:0]  CLEAR_LOW_RST  = 16'd7;
  localparam logic [DIST_W-1:0]  CLEAR_HIGH_RST = 16'd8;
  localparam logic [SCALE_W-1:0] SCALE_RST      = 20'd17826;

  // reported gate state codes
  localparam logic [1:0] GS_OPEN    = 2'd0;
  localparam logic [1:0] GS_CLOSED  = 2'd1;
  localparam logic [1:0] GS_MOVING  = 2'd2;
  localparam logic [1:0] GS_STOPPED = 2'd3;

  // led colour codes
  localparam logic [1:0] LED_GREEN  = 2'd0;
  localparam logic [1:0] LED_RED    = 2'd1;
  localparam logic [1:0] LED_YELLOW = 2'd2;
  localparam logic [1:0] LED_VIOLET = 2'd3;

  typedef enum logic [3:0] {
    MODE_OPEN    = 4'b0001,
    MODE_CLOSED  = 4'b0010,
    MODE_MOVING  = 4'b0100,
    MODE_STOPPED = 4'b1000
  } gate_mode_t;

  typedef struct packed {
    logic              command;
    logic              closed_switch;
    logic              open_switch;
    logic              button_level;
    logic [TIME_W-1:0] capture_time;
  } in_item_t;

  typedef struct packed {
    logic              motor_a;
    logic              motor_b;
    logic [1:0]        led_color;
    logic [1:0]        gate_state;
    logic [DIST_W-1:0] distance_cm;
  } out_item_t;

  typedef struct packed {
    logic closed_switch;
    logic open_switch;
    logic button_level;
  } gate_poll_t;

  typedef struct packed {
    logic       motor_a;
    logic       motor_b;
    logic [1:0] led_color;
    logic [1:0] gate_state;
  } gate_status_t;

  function automatic logic [1:0] mode_code(gate_mode_t m);
    logic [1:0] c;
    unique case (m)
      MODE_OPEN:    c = GS_OPEN;
      MODE_CLOSED:  c = GS_CLOSED;
      MODE_MOVING:  c = GS_MOVING;
      MODE_STOPPED: c = GS_STOPPED;
      default:      c = GS_OPEN;
    endcase
    return c;
  endfunction

  function automatic logic [1:0] mode_led(gate_mode_t m);
    logic [1:0] c;
    unique case (m)
      MODE_OPEN:    c = LED_GREEN;
      MODE_CLOSED:  c = LED_RED;
      MODE_MOVING:  c = LED_YELLOW;
      MODE_STOPPED: c = LED_VIOLET;
      default:      c = LED_GREEN;
    endcase
    return c;
  endfunction

endpackage

[design/gate_controller_with_echo_ranging.sv]
// Gate controller with echo ranging, top level.
// Channels: in_* carries poll or echo-capture requests (in_data.command 0 poll,
//   1 capture), out_* returns one result per request, cfg_* writes the clear
//   window (index 0 low, 1 high) and the q0.20 cm-per-tick scale (index 2).
//   A write to index 3 is taken and ignored; cfg_ready is always high.
// Path: a request accepted into the stage register moves on into the result
//   register once that register is empty or its result is being accepted.
// Throughput: one request per cycle when not stalled. The capture timestamp
//   subtraction sits before the stage register, the width-times-scale multiply,
//   saturation and the gate next-state logic sit before the result register.
// Stall: while out_valid is high and out_ready low the result holds; one more
//   request is taken into the stage register, then in_ready drops until the
//   result is accepted.
// Reset: rst_n low at a clock edge empties the pipeline, sets the gate open
//   with green led, bridge off, distance 0, the echo pairing to expect a rise
//   and the registers to low 7, high 8, scale 17826.
// Depends on gcer_pkg, gcer_echo_timer, gcer_range, gcer_gate_fsm and
//   gate_controller_with_echo_ranging_assert.svh.
`timescale 1ns / 1ps
`include "gate_controller_with_echo_ranging_assert.svh"

module gate_controller_with_echo_ranging import gcer_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  in_item_t           in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output out_item_t          out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [SCALE_W-1:0] cfg_data
);

  logic [DIST_W-1:0]  clear_low_r;
  logic [DIST_W-1:0]  clear_high_r;
  logic [SCALE_W-1:0] scale_r;

  logic               in_fire;
  logic               out_free;
  logic               s1_go;
  logic               s1_valid_r;
  logic               s1_valid_nxt;
  logic               s1_cmd_r;
  logic               s1_fall_r;
  gate_poll_t         s1_poll_r;
  logic [TIME_W-1:0]  s1_width_r;
  logic               out_valid_r;
  logic               out_valid_nxt;
  out_item_t          out_data_r;

  logic               echo_fall;
  logic [TIME_W-1:0]  echo_width;
  logic [DIST_W-1:0]  distance;
  logic [DIST_W-1:0]  dist_nxt;
  gate_status_t       stat_nxt;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clear_low_r  <= CLEAR_LOW_RST;
      clear_high_r <= CLEAR_HIGH_RST;
      scale_r      <= SCALE_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_CLEAR_LOW:  clear_low_r  <= cfg_data[DIST_W-1:0];
        CFG_CLEAR_HIGH: clear_high_r <= cfg_data[DIST_W-1:0];
        CFG_SCALE:      scale_r      <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign out_free = !out_valid_r || out_ready;
  assign s1_go    = s1_valid_r && out_free;
  assign in_ready = !s1_valid_r || out_free;
  assign in_fire  = in_valid && in_ready;

  gcer_echo_timer u_echo (
    .clk      (clk),
    .rst_n    (rst_n),
    .cap_en   (in_fire && in_data.command),
    .cap_time (in_data.capture_time),
    .is_fall  (echo_fall),
    .width    (echo_width)
  );

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_go) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_cmd_r                <= in_data.command;
      s1_fall_r               <= echo_fall;
      s1_width_r              <= echo_width;
      s1_poll_r.closed_switch <= in_data.closed_switch;
      s1_poll_r.open_switch   <= in_data.open_switch;
      s1_poll_r.button_level  <= in_data.button_level;
    end
  end

  gcer_range u_range (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (s1_go && s1_cmd_r && s1_fall_r),
    .width    (s1_width_r),
    .scale    (scale_r),
    .distance (distance),
    .dist_nxt (dist_nxt)
  );

  gcer_gate_fsm u_gate (
    .clk        (clk),
    .rst_n      (rst_n),
    .poll_en    (s1_go && !s1_cmd_r),
    .poll       (s1_poll_r),
    .distance   (distance),
    .clear_low  (clear_low_r),
    .clear_high (clear_high_r),
    .stat_nxt   (stat_nxt)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s1_go) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      out_data_r.motor_a     <= stat_nxt.motor_a;
      out_data_r.motor_b     <= stat_nxt.motor_b;
      out_data_r.led_color   <= stat_nxt.led_color;
      out_data_r.gate_state  <= stat_nxt.gate_state;
      out_data_r.distance_cm <= dist_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // assertions
  `GCER_ASSERT_NEXT(a_stage_hold, s1_valid_r && !out_free,
    s1_valid_r && $stable(s1_width_r) && $stable(s1_cmd_r), "stage request lost while stalled")
  `GCER_ASSERT_NEXT(a_stage_to_out, s1_go, out_valid_r, "stage request did not reach output")
  `GCER_ASSERT_NOW(a_bridge_safe, out_valid_r,
    !(out_data_r.motor_a && out_data_r.motor_b), "both bridge legs driven")
  `GCER_ASSERT_NOW(a_led_matches, out_valid_r,
    out_data_r.led_color == out_data_r.gate_state, "led colour disagrees with gate state")

endmodule

[design/gcer_echo_timer.sv]
// echo edge pairing: holds the rise timestamp and gives the pulse width on a fall
// depends on gcer_pkg
`timescale 1ns / 1ps

module gcer_echo_timer import gcer_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cap_en,
  input  logic [TIME_W-1:0] cap_time,
  output logic              is_fall,
  output logic [TIME_W-1:0] width
);

  logic              phase_r;
  logic              phase_nxt;
  logic [TIME_W-1:0] prev_r;
  logic [TIME_W-1:0] prev_nxt;

  assign is_fall = phase_r;
  // wraps modulo 2^32
  assign width   = cap_time - prev_r;

  always_comb begin
    phase_nxt = phase_r;
    prev_nxt  = prev_r;
    if (cap_en) begin
      phase_nxt = ~phase_r;
      prev_nxt  = cap_time;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= 1'b0;
      prev_r  <= '0;
    end else begin
      phase_r <= phase_nxt;
      prev_r  <= prev_nxt;
    end
  end

endmodule

[design/gcer_range.sv]
// pulse width to centimetres: one multiply by the q0.20 scale, then saturation
// depends on gcer_pkg
`timescale 1ns / 1ps

module gcer_range import gcer_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               load,
  input  logic [TIME_W-1:0]  width,
  input  logic [SCALE_W-1:0] scale,
  output logic [DIST_W-1:0]  distance,
  output logic [DIST_W-1:0]  dist_nxt
);

  logic [PROD_W-1:0] prod;
  logic [DIST_W-1:0] dist_r;
  logic              over;

  assign prod = PROD_W'(width) * PROD_W'(scale);
  assign over = |prod[PROD_W-1:FRAC_W+DIST_W];

  always_comb begin
    dist_nxt = dist_r;
    if (load) begin
      dist_nxt = over ? {DIST_W{1'b1}} : prod[FRAC_W+DIST_W-1:FRAC_W];
    end
  end

  assign distance = dist_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dist_r <= '0;
    end else begin
      dist_r <= dist_nxt;
    end
  end

endmodule

[design/gcer_gate_fsm.sv]
// gate state machine: limit switches, button edge and h-bridge drive
// depends on gcer_pkg
`timescale 1ns / 1ps

module gcer_gate_fsm import gcer_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              poll_en,
  input  gate_poll_t        poll,
  input  logic [DIST_W-1:0] distance,
  input  logic [DIST_W-1:0] clear_low,
  input  logic [DIST_W-1:0] clear_high,
  output gate_status_t      stat_nxt
);

  gate_mode_t mode_r;
  gate_mode_t mode_nxt;
  logic       last_r;
  logic       last_nxt;
  logic       btn_r;
  logic       btn_nxt;
  logic       a_r;
  logic       a_nxt;
  logic       b_r;
  logic       b_nxt;
  logic       path_clear;

  assign path_clear = (distance >= clear_low) && (distance <= clear_high);

  always_comb begin
    mode_nxt = mode_r;
    last_nxt = last_r;
    btn_nxt  = btn_r;
    a_nxt    = a_r;
    b_nxt    = b_r;
    if (poll_en) begin
      if (poll.closed_switch) begin
        mode_nxt = MODE_CLOSED;
        last_nxt = 1'b1;
      end else if (poll.open_switch) begin
        mode_nxt = MODE_OPEN;
        last_nxt = 1'b0;
      end else if (a_r == b_r) begin
        mode_nxt = MODE_STOPPED;
      end else begin
        mode_nxt = MODE_MOVING;
      end
      btn_nxt = poll.button_level;
      if (poll.button_level && !btn_r) begin
        unique case (mode_nxt)
          MODE_OPEN: begin
            if (path_clear) begin
              a_nxt = 1'b1;
              b_nxt = 1'b0;
            end
          end
          MODE_CLOSED: begin
            a_nxt = 1'b0;
            b_nxt = 1'b1;
          end
          MODE_MOVING: begin
            a_nxt = 1'b0;
            b_nxt = 1'b0;
          end
          MODE_STOPPED: begin
            a_nxt = last_nxt;
            b_nxt = ~last_nxt;
          end
          default: begin
            a_nxt = a_r;
            b_nxt = b_r;
          end
        endcase
      end
    end
  end

  always_comb begin
    stat_nxt.motor_a    = a_nxt;
    stat_nxt.motor_b    = b_nxt;
    stat_nxt.led_color  = mode_led(mode_nxt);
    stat_nxt.gate_state = mode_code(mode_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_OPEN;
      last_r <= 1'b0;
      btn_r  <= 1'b0;
      a_r    <= 1'b0;
      b_r    <= 1'b0;
    end else begin
      mode_r <= mode_nxt;
      last_r <= last_nxt;
      btn_r  <= btn_nxt;
      a_r    <= a_nxt;
      b_r    <= b_nxt;
    end
  end

endmodule

[tb/tb.sv]
// testbench for the gate controller with echo ranging: random polls and echo captures
// checked against an in-bench gate and distance model; needs gcer_pkg and the top level
`timescale 1ns / 1ps

import gcer_pkg::*;

class gate_result_board;
  logic [DIST_W-1:0]  clear_low;
  logic [DIST_W-1:0]  clear_high;
  logic [SCALE_W-1:0] scale;
  logic [1:0]         mode;
  logic [1:0]         led;
  logic               last_closed;
  logic               button_prev;
  logic               leg_a;
  logic               leg_b;
  logic               await_fall;
  logic [TIME_W-1:0]  edge_time;
  logic [DIST_W-1:0]  distance;
  out_item_t          awaited_results[$];
  int                 errors;

  function new();
    clear_low   = CLEAR_LOW_RST;
    clear_high  = CLEAR_HIGH_RST;
    scale       = SCALE_RST;
    mode        = GS_OPEN;
    led         = LED_GREEN;
    last_closed = 1'b0;
    button_prev = 1'b0;
    leg_a       = 1'b0;
    leg_b       = 1'b0;
    await_fall  = 1'b0;
    edge_time   = '0;
    distance    = '0;
    errors      = 0;
  endfunction

  function void write_register(logic [1:0] idx, logic [SCALE_W-1:0] val);
    case (idx)
      CFG_CLEAR_LOW:  clear_low = val[DIST_W-1:0];
      CFG_CLEAR_HIGH: clear_high = val[DIST_W-1:0];
      CFG_SCALE:      scale = val;
      default:        ;
    endcase
  endfunction

  function void note_request(in_item_t req);
    logic [TIME_W-1:0] width;
    logic [PROD_W-1:0] product;
    logic [PROD_W-1:0] cm;
    out_item_t         res;
    if (req.command) begin
      if (!await_fall) begin
        edge_time = req.capture_time;
        await_fall = 1'b1;
      end else begin
        width = req.capture_time - edge_time;
        product = {{SCALE_W{1'b0}}, width} * {{TIME_W{1'b0}}, scale};
        cm = product >> FRAC_W;
        distance = (cm > 65535) ? 16'hFFFF : cm[DIST_W-1:0];
        edge_time = req.capture_time;
        await_fall = 1'b0;
      end
    end else begin
      if (req.closed_switch) begin
        mode = GS_CLOSED;
        led = LED_RED;
        last_closed = 1'b1;
      end else if (req.open_switch) begin
        mode = GS_OPEN;
        led = LED_GREEN;
        last_closed = 1'b0;
      end else if (leg_a == leg_b) begin
        mode = GS_STOPPED;
        led = LED_VIOLET;
      end else begin
        mode = GS_MOVING;
        led = LED_YELLOW;
      end
      if (req.button_level != button_prev) begin
        button_prev = req.button_level;
        if (req.button_level) begin
          case (mode)
            GS_OPEN: begin
              if (distance >= clear_low && distance <= clear_high) {leg_a, leg_b} = 2'b10;
            end
            GS_CLOSED: {leg_a, leg_b} = 2'b01;
            GS_MOVING: {leg_a, leg_b} = 2'b00;
            default:   {leg_a, leg_b} = last_closed ? 2'b10 : 2'b01;
          endcase
        end
      end
    end
    res.motor_a     = leg_a;
    res.motor_b     = leg_b;
    res.led_color   = led;
    res.gate_state  = mode;
    res.distance_cm = distance;
    awaited_results.push_back(res);
  endfunction

  function void check_field(string field_name, logic [DIST_W-1:0] want, logic [DIST_W-1:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field_name, want, got);
    end
  endfunction

  function void check_result(out_item_t got);
    out_item_t want;
    if (awaited_results.size() == 0) begin
      errors++;
      $display("%0t: result with none expected, expected nothing, actual %h", $time, got);
      return;
    end
    want = awaited_results.pop_front();
    check_field("motor_a", DIST_W'(want.motor_a), DIST_W'(got.motor_a));
    check_field("motor_b", DIST_W'(want.motor_b), DIST_W'(got.motor_b));
    check_field("led_color", DIST_W'(want.led_color), DIST_W'(got.led_color));
    check_field("gate_state", DIST_W'(want.gate_state), DIST_W'(got.gate_state));
    check_field("distance_cm", want.distance_cm, got.distance_cm);
  endfunction
endclass

module tb;
  localparam logic CMD_POLL    = 1'b0;
  localparam logic CMD_CAPTURE = 1'b1;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  in_item_t           in_data;
  logic               out_valid;
  logic               out_ready;
  out_item_t          out_data;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [1:0]         cfg_index;
  logic [SCALE_W-1:0] cfg_data;

  gate_result_board board = new();
  int               burst_left = 0;
  bit               hold_off_req = 0;

  gate_controller_with_echo_ranging dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  // handshake monitor
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) board.write_register(cfg_index, cfg_data);
      if (in_valid && in_ready) board.note_request(in_data);
      if (out_valid && out_ready) board.check_result(out_data);
    end
  end

  // receiver stall pattern
  initial begin
    int ready_pct;
    int segment_left;
    ready_pct = 100;
    segment_left = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        hold_off_req = 0;
        out_ready <= 1'b0;
        repeat (300) @(posedge clk);
      end else begin
        if (segment_left == 0) begin
          case ($urandom_range(3))
            0: ready_pct = 100;
            1: ready_pct = 75;
            2: ready_pct = 40;
            default: ready_pct = 10;
          endcase
          segment_left = $urandom_range(20, 200);
        end
        segment_left--;
        out_ready <= ($urandom_range(99) < ready_pct);
      end
    end
  end

  task automatic send_request(input in_item_t req);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = $urandom_range(1, 40);
    end
    in_valid <= 1'b1;
    in_data <= req;
    do @(posedge clk); while (!in_ready);
    burst_left--;
  endtask

  task automatic send_poll(input logic closed_sw, input logic open_sw, input logic button);
    in_item_t req;
    req.command = CMD_POLL;
    req.closed_switch = closed_sw;
    req.open_switch = open_sw;
    req.button_level = button;
    req.capture_time = $urandom;
    send_request(req);
  endtask

  task automatic send_capture(input logic [TIME_W-1:0] stamp);
    in_item_t req;
    req.command = CMD_CAPTURE;
    req.closed_switch = 1'($urandom_range(1));
    req.open_switch = 1'($urandom_range(1));
    req.button_level = 1'($urandom_range(1));
    req.capture_time = stamp;
    send_request(req);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    burst_left = 0;
    while (board.awaited_results.size() != 0) @(posedge clk);
  endtask

  task automatic set_window(input logic [DIST_W-1:0] low, input logic [DIST_W-1:0] high,
                            input logic [SCALE_W-1:0] scale);
    logic [SCALE_W-1:0] vals[3];
    logic [1:0]         idx[3];
    vals = '{{4'd0, low}, {4'd0, high}, scale};
    idx = '{CFG_CLEAR_LOW, CFG_CLEAR_HIGH, CFG_SCALE};
    for (int i = 0; i < 3; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data <= vals[i];
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [TIME_W-1:0] pick_width();
    longint unsigned target;
    longint unsigned w;
    case ($urandom_range(3))
      0: begin
        if (board.scale != 0 && board.clear_low <= board.clear_high) begin
          target = $urandom_range(board.clear_low, board.clear_high);
          w = ((target << FRAC_W) + board.scale - 1) / board.scale;
          return (w > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : w[TIME_W-1:0];
        end
        return $urandom_range(0, 2000);
      end
      1: return $urandom_range(0, 2000);
      2: return $urandom_range(0, 200000);
      default: return $urandom;
    endcase
  endfunction

  task automatic run_random(input int count);
    logic [TIME_W-1:0] rise;
    int                pick;
    int                sent;
    sent = 0;
    while (sent < count) begin
      pick = $urandom_range(99);
      if (pick < 25) begin
        rise = $urandom;
        send_capture(rise);
        send_capture(rise + pick_width());
        sent += 2;
      end else if (pick < 30) begin
        send_capture($urandom);
        sent++;
      end else begin
        pick = $urandom_range(99);
        send_poll(pick < 15 || pick >= 95, (pick >= 15 && pick < 30) || pick >= 95,
                  1'($urandom_range(1)));
        sent++;
      end
    end
  endtask

  task automatic run_directed();
    send_poll(1'b1, 1'b1, 1'b0);
    send_poll(1'b0, 1'b1, 1'b0);
    send_capture(32'd0);
    send_capture(32'd470);
    send_poll(1'b0, 1'b1, 1'b1);
    send_poll(1'b0, 1'b0, 1'b1);
    send_poll(1'b0, 1'b0, 1'b0);
    send_poll(1'b0, 1'b0, 1'b1);
    send_poll(1'b0, 1'b0, 1'b0);
    send_poll(1'b0, 1'b0, 1'b1);
    send_poll(1'b1, 1'b0, 1'b0);
    send_poll(1'b1, 1'b0, 1'b1);
    send_poll(1'b0, 1'b0, 1'b0);
    send_poll(1'b0, 1'b0, 1'b1);
    send_poll(1'b0, 1'b0, 1'b0);
    send_poll(1'b0, 1'b0, 1'b1);
    send_capture(32'hFFFF_FF00);
    send_capture(32'h0000_0100);
    send_capture(32'h1234_5678);
    send_capture(32'h1234_5677);
    send_poll(1'b0, 1'b1, 1'b0);
    send_poll(1'b0, 1'b1, 1'b1);
  endtask

  initial begin
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_data <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= CFG_CLEAR_LOW;
    cfg_data <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    run_directed();
    run_random(130);
    hold_off_req = 1;
    run_random(135);
    wait_drained();

    set_window(16'd0, 16'hFFFF, 20'hFFFFF);
    run_random(265);
    wait_drained();

    // inverted window, zero scale
    set_window(16'd100, 16'd50, 20'd0);
    run_random(265);
    wait_drained();

    set_window(16'd20, 16'd400, SCALE_W'($urandom_range(1000, 200000)));
    run_random(265);
    wait_drained();

    set_window(16'hFFFF, 16'hFFFF, 20'hFFFFF);
    run_random(265);
    wait_drained();

    set_window(16'd0, 16'd0, 20'd1);
    run_random(265);
    wait_drained();

    repeat (10) @(posedge clk);
    if (board.errors == 0 && board.awaited_results.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
